### design/snsd_pkg.sv
// Package for the sensor noise standard deviation estimator.
// Holds the beat types, action and register codes, reset values and the
// controller state and command types. No dependencies.
package snsd_pkg;

  localparam int SAMPLE_BITS        = 16;
  localparam int MEAN_FRAC_BITS_DEF = 16;
  localparam int SUM_BITS           = 48;
  localparam int CFG_DATA_BITS      = 14;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  localparam logic [1:0] CFG_SAMPLE_TARGET    = 2'd0;
  localparam logic [1:0] CFG_VARIANCE_DIVISOR = 2'd1;
  localparam logic [1:0] CFG_REJECT_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT_MS       = 2'd3;

  localparam logic [5:0]  TARGET_RST    = 6'd49;
  localparam logic [6:0]  DIVISOR_RST   = 7'd50;
  localparam logic [11:0] THRESHOLD_RST = 12'd125;
  localparam logic [13:0] TIMEOUT_RST   = 14'd10000;

  localparam logic [13:0] ELAPSED_MAX = 14'h3fff;
  localparam logic [14:0] STD_MAX     = 15'h7fff;
  localparam int          ONE_G       = 4096;

  typedef struct packed {
    logic [1:0]                    action;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [14:0] std_dev;
    logic [5:0]  samples_used;
    logic        timed_out;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_MEAN_UPD,
    ST_MUL,
    ST_SUM_UPD,
    ST_FIN_LOAD,
    ST_DIV_VAR,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic tick;
    logic sample_load;
    logic div_step;
    logic mean_upd;
    logic mul_step;
    logic sum_upd;
    logic fin_load;
    logic sqrt_load;
    logic sqrt_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic running;
    logic sample_ok;
    logic expired;
    logic target_hit;
    logic out_busy;
  } dp_status_t;

endpackage

### design/snsd_ctrl.sv
// Sequencing state machine of the estimator.
// Depends on snsd_pkg; drives the datapath through ctrl_cmd_t commands.
module snsd_ctrl #(
  parameter int MEAN_FRAC_BITS = snsd_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           action,
  input  snsd_pkg::dp_status_t status,
  output snsd_pkg::ctrl_cmd_t  cmd
);

  localparam int MW  = snsd_pkg::SAMPLE_BITS + MEAN_FRAC_BITS;
  localparam int AW  = MW + 1;
  localparam int VW  = snsd_pkg::SUM_BITS - MEAN_FRAC_BITS;
  localparam int DW  = (AW > VW) ? AW : VW;
  localparam int SQH = (VW + (VW % 2)) / 2;
  localparam int CW  = $clog2(DW + 1);

  localparam logic [CW-1:0] DIV_LAST  = CW'(DW - 1);
  localparam logic [CW-1:0] MUL_LAST  = CW'(AW - 1);
  localparam logic [CW-1:0] SQRT_LAST = CW'(SQH - 1);

  snsd_pkg::state_t state, state_next;
  logic [CW-1:0]    cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= snsd_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) cnt <= '0;
      else if (cmd.div_step || cmd.mul_step || cmd.sqrt_step) cnt <= cnt + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      snsd_pkg::ST_IDLE: begin
        if (in_valid && status.running) begin
          if (action == snsd_pkg::ACT_SAMPLE && status.sample_ok)
            state_next = snsd_pkg::ST_DIV_MEAN;
          else if (action == snsd_pkg::ACT_TICK && status.expired)
            state_next = snsd_pkg::ST_FIN_LOAD;
        end
      end
      snsd_pkg::ST_DIV_MEAN:  if (cnt == DIV_LAST) state_next = snsd_pkg::ST_MEAN_UPD;
      snsd_pkg::ST_MEAN_UPD:  state_next = snsd_pkg::ST_MUL;
      snsd_pkg::ST_MUL:       if (cnt == MUL_LAST) state_next = snsd_pkg::ST_SUM_UPD;
      snsd_pkg::ST_SUM_UPD:
        state_next = status.target_hit ? snsd_pkg::ST_FIN_LOAD : snsd_pkg::ST_IDLE;
      snsd_pkg::ST_FIN_LOAD:  state_next = snsd_pkg::ST_DIV_VAR;
      snsd_pkg::ST_DIV_VAR:   if (cnt == DIV_LAST) state_next = snsd_pkg::ST_SQRT_LOAD;
      snsd_pkg::ST_SQRT_LOAD: state_next = snsd_pkg::ST_SQRT;
      snsd_pkg::ST_SQRT:      if (cnt == SQRT_LAST) state_next = snsd_pkg::ST_EMIT;
      snsd_pkg::ST_EMIT:      if (!status.out_busy) state_next = snsd_pkg::ST_IDLE;
      default:                state_next = snsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      snsd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.clear       = (action == snsd_pkg::ACT_START);
          cmd.tick        = (action == snsd_pkg::ACT_TICK) && status.running;
          cmd.sample_load = (action == snsd_pkg::ACT_SAMPLE) && status.running &&
                            status.sample_ok;
        end
      end
      snsd_pkg::ST_DIV_MEAN:  cmd.div_step  = 1'b1;
      snsd_pkg::ST_MEAN_UPD:  cmd.mean_upd  = 1'b1;
      snsd_pkg::ST_MUL:       cmd.mul_step  = 1'b1;
      snsd_pkg::ST_SUM_UPD:   cmd.sum_upd   = 1'b1;
      snsd_pkg::ST_FIN_LOAD:  cmd.fin_load  = 1'b1;
      snsd_pkg::ST_DIV_VAR:   cmd.div_step  = 1'b1;
      snsd_pkg::ST_SQRT_LOAD: cmd.sqrt_load = 1'b1;
      snsd_pkg::ST_SQRT:      cmd.sqrt_step = 1'b1;
      snsd_pkg::ST_EMIT:      cmd.out_load  = !status.out_busy;
      default:                cmd = '0;
    endcase
  end

endmodule

### design/snsd_dpath.sv
// Datapath of the estimator: run state, configuration registers, a shared
// serial divider, a shift-add multiplier, a serial square root and the
// output register. Depends on snsd_pkg.
module snsd_dpath #(
  parameter int MEAN_FRAC_BITS = snsd_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  snsd_pkg::ctrl_cmd_t   cmd,
  output snsd_pkg::dp_status_t  status,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [snsd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  snsd_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output snsd_pkg::out_item_t   out_data
);

  localparam int SB  = snsd_pkg::SAMPLE_BITS;
  localparam int F   = MEAN_FRAC_BITS;
  localparam int SW  = snsd_pkg::SUM_BITS;
  localparam int MW  = SB + F;
  localparam int AW  = MW + 1;
  localparam int VW  = SW - F;
  localparam int DW  = (AW > VW) ? AW : VW;
  localparam int SQW = VW + (VW % 2);
  localparam int SQH = SQW / 2;
  localparam int XW  = SB + 2;
  localparam int PW  = 2 * AW - F;
  localparam int EW  = (PW > SW) ? PW : SW;
  localparam logic [EW:0] SUM_MAX = {{(EW + 1 - SW){1'b0}}, {SW{1'b1}}};
  localparam logic signed [XW-1:0] ONE_G_S = XW'(snsd_pkg::ONE_G);

  // Configuration registers.
  logic [5:0]  sample_target;
  logic [6:0]  variance_divisor;
  logic [11:0] reject_threshold;
  logic [13:0] timeout_ms;

  // Run state.
  logic                 running;
  logic [5:0]           accepted_count;
  logic signed [MW-1:0] running_mean;
  logic [SW-1:0]        squared_dev_sum;
  logic [13:0]          elapsed_ms;
  logic                 timed;

  // Working registers.
  logic signed [MW-1:0] xs;
  logic [AW-1:0]        dmag;
  logic                 dneg;
  logic [DW-1:0]        quo;
  logic [6:0]           rem;
  logic [6:0]           den;
  logic [2*AW-1:0]      prod;
  logic [SQW-1:0]       sq_v;
  logic [SQH+1:0]       sq_rem;
  logic [SQH-1:0]       root;

  // Sample acceptance window.
  logic signed [XW-1:0] x_ext, dist_s;
  logic [XW-1:0]        dist_mag;
  always_comb begin
    x_ext    = XW'(in_data.sample);
    dist_s   = ONE_G_S - x_ext;
    dist_mag = dist_s[XW-1] ? XW'(-dist_s) : XW'(dist_s);
  end

  logic [14:0] elapsed_inc;
  logic [5:0]  count_inc;
  logic [5:0]  target_eff;
  assign elapsed_inc = {1'b0, elapsed_ms} + 15'd1;
  assign count_inc   = accepted_count + 6'd1;
  assign target_eff  = (sample_target == '0) ? 6'd1 : sample_target;

  assign status.running    = running;
  assign status.sample_ok  = dist_mag <= XW'(reject_threshold);
  assign status.expired    = elapsed_inc > {1'b0, timeout_ms};
  assign status.target_hit = accepted_count >= target_eff;
  assign status.out_busy   = out_valid && !out_ready;

  // Deviation of the new sample from the current mean.
  logic signed [MW-1:0] xs_in;
  logic signed [AW-1:0] d_old;
  assign xs_in = {in_data.sample, {F{1'b0}}};
  assign d_old = AW'(xs_in) - AW'(running_mean);

  // Divider step, restoring, one quotient bit per cycle.
  logic [7:0] rem_sh;
  logic       q_bit;
  assign rem_sh = {rem, quo[DW-1]};
  assign q_bit  = rem_sh >= {1'b0, den};

  // Mean update and new deviation.
  logic [AW-1:0]        q_mag;
  logic [AW-1:0]        q_s;
  logic signed [MW-1:0] mean_next;
  logic signed [AW-1:0] d_new;
  always_comb begin
    q_mag     = quo[AW-1:0];
    q_s       = dneg ? (~q_mag + 1'b1) : q_mag;
    mean_next = running_mean + $signed(q_s[MW-1:0]);
    d_new     = AW'(xs) - AW'(mean_next);
  end

  // Multiplier step: add the multiplicand into the upper half, shift right.
  logic [AW:0] mul_sum;
  assign mul_sum = {1'b0, prod[2*AW-1:AW]} + (prod[0] ? {1'b0, dmag} : '0);

  // Sum accumulation with saturation.
  logic [EW:0] sum_tot_w;
  assign sum_tot_w = (EW + 1)'(prod[2*AW-1:F]) + (EW + 1)'(squared_dev_sum);

  // Square root step, two operand bits per cycle.
  logic [SQH+3:0] sq_sh;
  logic [SQH+3:0] sq_trial;
  logic           sq_ok;
  assign sq_sh    = {sq_rem, sq_v[SQW-1:SQW-2]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ok    = sq_sh >= sq_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_target    <= snsd_pkg::TARGET_RST;
      variance_divisor <= snsd_pkg::DIVISOR_RST;
      reject_threshold <= snsd_pkg::THRESHOLD_RST;
      timeout_ms       <= snsd_pkg::TIMEOUT_RST;
      running          <= 1'b0;
      accepted_count   <= '0;
      running_mean     <= '0;
      squared_dev_sum  <= '0;
      elapsed_ms       <= '0;
      timed            <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          snsd_pkg::CFG_SAMPLE_TARGET:    sample_target    <= cfg_data[5:0];
          snsd_pkg::CFG_VARIANCE_DIVISOR: variance_divisor <= cfg_data[6:0];
          snsd_pkg::CFG_REJECT_THRESHOLD: reject_threshold <= cfg_data[11:0];
          snsd_pkg::CFG_TIMEOUT_MS:       timeout_ms       <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        running         <= 1'b1;
        accepted_count  <= '0;
        running_mean    <= '0;
        squared_dev_sum <= '0;
        elapsed_ms      <= '0;
        timed           <= 1'b0;
      end
      if (cmd.tick) begin
        elapsed_ms <= elapsed_inc[14] ? snsd_pkg::ELAPSED_MAX : elapsed_inc[13:0];
        timed      <= status.expired;
      end
      if (cmd.sample_load) begin
        accepted_count <= count_inc;
        timed          <= 1'b0;
      end
      if (cmd.mean_upd) running_mean <= mean_next;
      if (cmd.sum_upd) begin
        if (sum_tot_w > SUM_MAX) squared_dev_sum <= {SW{1'b1}};
        else squared_dev_sum <= sum_tot_w[SW-1:0];
      end
      if (cmd.fin_load) running <= 1'b0;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_load) begin
      xs   <= xs_in;
      dneg <= d_old[AW-1];
      dmag <= d_old[AW-1] ? AW'(-d_old) : AW'(d_old);
      quo  <= DW'(d_old[AW-1] ? AW'(-d_old) : AW'(d_old));
      rem  <= '0;
      den  <= (count_inc == '0) ? 7'd64 : {1'b0, count_inc};
    end
    if (cmd.fin_load) begin
      quo <= DW'(squared_dev_sum[SW-1:F]);
      rem <= '0;
      den <= (variance_divisor == '0) ? 7'd1 : variance_divisor;
    end
    if (cmd.div_step) begin
      quo <= {quo[DW-2:0], q_bit};
      rem <= q_bit ? 7'(rem_sh - {1'b0, den}) : rem_sh[6:0];
    end
    if (cmd.mean_upd) begin
      // The old magnitude stays in dmag as the multiplicand.
      prod <= {{AW{1'b0}}, (d_new[AW-1] ? AW'(-d_new) : AW'(d_new))};
    end
    if (cmd.mul_step) prod <= {mul_sum, prod[AW-1:1]};
    if (cmd.sqrt_load) begin
      sq_v   <= SQW'(quo[VW-1:0]);
      sq_rem <= '0;
      root   <= '0;
    end
    if (cmd.sqrt_step) begin
      sq_v   <= {sq_v[SQW-3:0], 2'b00};
      sq_rem <= sq_ok ? (SQH + 2)'(sq_sh - sq_trial) : (SQH + 2)'(sq_sh);
      root   <= {root[SQH-2:0], sq_ok};
    end
    if (cmd.out_load) begin
      out_data.std_dev      <= (SQH > 15 && root > SQH'(snsd_pkg::STD_MAX)) ?
                               snsd_pkg::STD_MAX : 15'(root);
      out_data.samples_used <= accepted_count;
      out_data.timed_out    <= timed;
    end
  end

endmodule

### design/sensor_noise_std_dev_estimator.sv
// Usage notes for the sensor noise standard deviation estimator.
// Input channel in_valid/in_ready/in_data carries one action per beat:
// start a run, a Q3.12 g sample, or a one millisecond tick.
// Output channel out_valid/out_ready/out_data carries one beat per finished
// run: std_dev in Q12 g, samples used and a timeout flag.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user must
// write it only while the block is idle, and the block itself does not enforce this.
// Start beats, rejected samples and ticks that leave the run open are handled
// in the idle state. An accepted sample passes the states DIV_MEAN (serial
// divider), MEAN_UPD, MUL (shift-add multiplier) and SUM_UPD, and in_ready
// stays low until it is done.
// A run that ends then passes FIN_LOAD, DIV_VAR (divider), SQRT_LOAD and SQRT
// (square root) before the result beat is written in EMIT.
// The result sits in an output register; while the receiver stalls the
// block keeps taking beats until it has a new result to write.
// Reset restores the register defaults and leaves no run open.
module sensor_noise_std_dev_estimator #(
  parameter int MEAN_FRAC_BITS = snsd_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  snsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output snsd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [snsd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  snsd_pkg::ctrl_cmd_t  cmd;
  snsd_pkg::dp_status_t status;

  snsd_ctrl #(.MEAN_FRAC_BITS(MEAN_FRAC_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (in_data.action),
    .status   (status),
    .cmd      (cmd)
  );

  snsd_dpath #(.MEAN_FRAC_BITS(MEAN_FRAC_BITS)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### design/snsd_chk.sv
// Port-level checker for the estimator, bound to the top level.
// Depends on snsd_pkg and sensor_noise_std_dev_estimator.
module snsd_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input snsd_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input snsd_pkg::out_item_t out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A run that reached its target used at least one sample.
  a_target_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.timed_out |-> out_data.samples_used != 6'd0)
    else $error("target result with no samples");

  // A start beat never produces a result.
  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.action == snsd_pkg::ACT_START
      |=> !$rose(out_valid))
    else $error("result after start beat");

  // Nothing is shown right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sensor_noise_std_dev_estimator snsd_chk u_snsd_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### dv/snsd_checker.sv
// Checker for the sensor noise standard deviation estimator: watches the input,
// output and register write ports, predicts every result beat and compares it.
// Depends on snsd_pkg for the beat types, action and register codes.
module snsd_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  snsd_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  snsd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [snsd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                  errors,
  output int                  pending
);

  localparam int FRAC = snsd_pkg::MEAN_FRAC_BITS_DEF;
  localparam logic [63:0] SUM_LIMIT = (64'd1 << snsd_pkg::SUM_BITS) - 64'd1;

  logic [5:0]  target_q;
  logic [6:0]  divisor_q;
  logic [11:0] thresh_q;
  logic [13:0] timeout_q;

  logic        run_open;
  logic [5:0]  n_acc;
  longint      mean_acc;
  logic [63:0] dev_sum;
  logic [13:0] ms_count;

  snsd_pkg::out_item_t result_q[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic snsd_pkg::out_item_t close_run(logic flag);
    snsd_pkg::out_item_t r;
    logic [63:0] dv;
    logic [63:0] sd;
    dv = (divisor_q == 0) ? 64'd1 : 64'(divisor_q);
    sd = int_sqrt(dev_sum / (dv << FRAC));
    r.std_dev = (sd > 64'(snsd_pkg::STD_MAX)) ? snsd_pkg::STD_MAX : sd[14:0];
    r.samples_used = n_acc;
    r.timed_out = flag;
    return r;
  endfunction

  task automatic predict_beat(snsd_pkg::in_item_t it);
    longint      x;
    longint      dist_mag;
    longint      xs;
    longint      d_old;
    longint      d_new;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] prod;
    logic [5:0]  tgt;
    case (it.action)
      snsd_pkg::ACT_START: begin
        run_open = 1;
        n_acc = 0;
        mean_acc = 0;
        dev_sum = 0;
        ms_count = 0;
      end
      snsd_pkg::ACT_SAMPLE: if (run_open) begin
        x = longint'(it.sample);
        dist_mag = longint'(snsd_pkg::ONE_G) - x;
        if (dist_mag < 0) dist_mag = -dist_mag;
        if (dist_mag <= longint'(thresh_q)) begin
          n_acc = n_acc + 1;
          xs = x * (longint'(1) << FRAC);
          d_old = xs - mean_acc;
          mean_acc = mean_acc + d_old / ((n_acc == 0) ? 64 : longint'(n_acc));
          d_new = xs - mean_acc;
          a = (d_old < 0) ? 64'(-d_old) : 64'(d_old);
          b = (d_new < 0) ? 64'(-d_new) : 64'(d_new);
          prod = a * (b >> FRAC) + ((a * (b & ((64'd1 << FRAC) - 1))) >> FRAC);
          if (prod > SUM_LIMIT || dev_sum + prod > SUM_LIMIT) dev_sum = SUM_LIMIT;
          else dev_sum = dev_sum + prod;
          tgt = (target_q == 0) ? 6'd1 : target_q;
          if (n_acc >= tgt) begin
            result_q.push_back(close_run(1'b0));
            run_open = 0;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Tick timeout check kept apart: the elapsed count after the increment decides it.
  task automatic tick_beat();
    logic [14:0] nxt;
    nxt = 15'(ms_count) + 15'd1;
    ms_count = (nxt > 15'(snsd_pkg::ELAPSED_MAX)) ? snsd_pkg::ELAPSED_MAX : nxt[13:0];
    if (nxt > 15'(timeout_q)) begin
      result_q.push_back(close_run(1'b1));
      run_open = 0;
    end
  endtask

  always @(posedge clk) begin
    snsd_pkg::out_item_t e;
    if (rst) begin
      target_q = snsd_pkg::TARGET_RST;
      divisor_q = snsd_pkg::DIVISOR_RST;
      thresh_q = snsd_pkg::THRESHOLD_RST;
      timeout_q = snsd_pkg::TIMEOUT_RST;
      run_open = 0;
      n_acc = 0;
      mean_acc = 0;
      dev_sum = 0;
      ms_count = 0;
      result_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          snsd_pkg::CFG_SAMPLE_TARGET:    target_q = cfg_data[5:0];
          snsd_pkg::CFG_VARIANCE_DIVISOR: divisor_q = cfg_data[6:0];
          snsd_pkg::CFG_REJECT_THRESHOLD: thresh_q = cfg_data[11:0];
          snsd_pkg::CFG_TIMEOUT_MS:       timeout_q = cfg_data[13:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result beat with no expectation: %p", out_data);
          errors++;
        end else begin
          e = result_q.pop_front();
          if (out_data.std_dev !== e.std_dev) begin
            $error("std_dev expected %0d actual %0d", e.std_dev, out_data.std_dev);
            errors++;
          end
          if (out_data.samples_used !== e.samples_used) begin
            $error("samples_used expected %0d actual %0d", e.samples_used,
                   out_data.samples_used);
            errors++;
          end
          if (out_data.timed_out !== e.timed_out) begin
            $error("timed_out expected %0d actual %0d", e.timed_out, out_data.timed_out);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.action == snsd_pkg::ACT_TICK) begin
          if (run_open) tick_beat();
        end else begin
          predict_beat(in_data);
        end
      end
    end
    pending = result_q.size();
  end
endmodule

### dv/sensor_noise_std_dev_estimator_tb.sv
// Testbench top for the sensor noise standard deviation estimator: drives
// directed and random beats and register settings, and gives the verdict.
// Depends on snsd_pkg, the block and snsd_checker.
module sensor_noise_std_dev_estimator_tb;

  // Action code that the block leaves unused.
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  snsd_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  snsd_pkg::out_item_t out_data;
  logic      cfg_we = 0;
  logic [1:0] cfg_index = snsd_pkg::CFG_SAMPLE_TARGET;
  logic [snsd_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  int        errors;
  int        pending;

  logic      long_hold = 0;
  logic      rx_fast = 0;
  logic      tx_fast = 0;
  int        thr_now = 125;
  int        beats_sent = 0;

  sensor_noise_std_dev_estimator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  snsd_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always #10 clk = ~clk;

  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: a random wait before each beat unless rx_fast is set, or one long hold-off on request.
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (3000) @(negedge clk);
        long_hold = 0;
      end
      n = rx_fast ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Called at a falling edge; leaves valid high until the caller idles.
  task automatic send_beat(logic [1:0] act, logic [15:0] smp);
    int n;
    snsd_pkg::in_item_t it;
    n = tx_fast ? 0 : $urandom_range(0, 7);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    it.action = act;
    it.sample = smp;
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    beats_sent++;
  endtask

  // Drain: sender pauses until every expected result is in, then lets an
  // unfinished accepted sample settle before the register is touched.
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[snsd_pkg::CFG_DATA_BITS-1:0];
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic set_all(int tgt, int dv, int thr, int tmo);
    drain();
    write_reg(snsd_pkg::CFG_SAMPLE_TARGET, tgt);
    write_reg(snsd_pkg::CFG_VARIANCE_DIVISOR, dv);
    write_reg(snsd_pkg::CFG_REJECT_THRESHOLD, thr);
    write_reg(snsd_pkg::CFG_TIMEOUT_MS, tmo);
    thr_now = thr;
  endtask

  function automatic logic [15:0] near_one_g();
    int span;
    span = thr_now + 4;
    return 16'(snsd_pkg::ONE_G + $urandom_range(0, 2 * span) - span);
  endfunction

  // One random run: mostly samples near 1 g, some ticks, a little noise.
  task automatic random_run(int len);
    int k;
    int r;
    send_beat(snsd_pkg::ACT_START, 16'($urandom));
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_beat(snsd_pkg::ACT_SAMPLE, near_one_g());
      else if (r < 88) send_beat(snsd_pkg::ACT_TICK, 16'($urandom));
      else if (r < 94) send_beat(snsd_pkg::ACT_SAMPLE, 16'($urandom));
      else if (r < 97) send_beat(ACT_RESERVED, 16'($urandom));
      else send_beat(snsd_pkg::ACT_START, 16'($urandom));
    end
  endtask

  initial begin
    int p;
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: beats while idle are ignored, extremes, rejection at the edge.
    send_beat(snsd_pkg::ACT_SAMPLE, 16'h7fff);
    send_beat(snsd_pkg::ACT_TICK, 16'h8000);
    send_beat(ACT_RESERVED, 16'hffff);
    send_beat(snsd_pkg::ACT_START, 16'h0000);
    send_beat(snsd_pkg::ACT_SAMPLE, 16'd4096);
    send_beat(snsd_pkg::ACT_SAMPLE, 16'd4221);
    send_beat(snsd_pkg::ACT_SAMPLE, 16'd4222);
    send_beat(snsd_pkg::ACT_SAMPLE, 16'd3971);
    send_beat(snsd_pkg::ACT_SAMPLE, 16'h8000);
    send_beat(snsd_pkg::ACT_START, 16'h0000);
    send_beat(snsd_pkg::ACT_SAMPLE, 16'd4000);
    set_all(1, 1, 4095, 1);
    send_beat(snsd_pkg::ACT_START, 16'h0);
    send_beat(snsd_pkg::ACT_SAMPLE, 16'h8000);
    send_beat(snsd_pkg::ACT_START, 16'h0);
    send_beat(snsd_pkg::ACT_TICK, 16'h0);
    send_beat(snsd_pkg::ACT_TICK, 16'h0);
    set_all(0, 0, 0, 0);
    send_beat(snsd_pkg::ACT_START, 16'h0);
    send_beat(snsd_pkg::ACT_SAMPLE, 16'd4097);
    send_beat(snsd_pkg::ACT_SAMPLE, 16'd4096);
    send_beat(snsd_pkg::ACT_START, 16'h0);
    send_beat(snsd_pkg::ACT_TICK, 16'h0);
    set_all(63, 64, 4095, 16383);
    send_beat(snsd_pkg::ACT_START, 16'h0);
    send_beat(snsd_pkg::ACT_SAMPLE, 16'h7fff);
    send_beat(snsd_pkg::ACT_SAMPLE, 16'h8001);

    // Long receiver hold-off with one result per sample, so the block backs up.
    set_all(1, 1, 4095, 16383);
    long_hold = 1;
    for (p = 0; p < 12; p++) begin
      send_beat(snsd_pkg::ACT_START, 16'h0);
      send_beat(snsd_pkg::ACT_SAMPLE, near_one_g());
    end

    // Random phases with random settings, a few at the extremes.
    p = 0;
    while (beats_sent < 1100) begin
      case (p % 6)
        0: set_all($urandom_range(1, 8), $urandom_range(1, 64), $urandom_range(0, 400),
                   $urandom_range(1, 12));
        1: set_all(63, 64, 4095, $urandom_range(20, 60));
        2: set_all($urandom_range(1, 4), 1, $urandom_range(0, 4095), 16383);
        3: set_all(0, 0, $urandom_range(50, 200), 0);
        default: set_all($urandom_range(1, 63), $urandom_range(0, 64),
                         $urandom_range(0, 4095), $urandom_range(0, 40));
      endcase
      rx_fast = (p % 5 == 4);
      tx_fast = (p % 7 == 3);
      repeat (4) random_run($urandom_range(5, 30));
      p++;
    end
    rx_fast = 0;
    tx_fast = 0;

    drain();
    repeat (300) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
